>>> rtl/egx_pkg.sv
// ============================================================================
// egx_pkg: shared types and constants for the ExpGaussExp shape evaluator
// Field widths, fixed-point constants, register indexes and stage tags.
// ============================================================================
`default_nettype none

package egx_pkg;

  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int X_W     = 16;   // sample / center, Q4.12
  localparam int MAG_W   = 16;   // |sample - center|
  localparam int W_W     = 16;   // widths, Q2.14
  localparam int SLOPE_W = 15;   // tail slopes, Q3.12
  localparam int NUM_W   = 30;   // dividend |d| << 14
  localparam int Q_W     = 30;   // |t| in Q.12
  localparam int PROD_W  = 46;   // slope * |t|, or |t|^2 in the core
  localparam int ASQ_W   = 30;   // slope^2
  localparam int E_W     = 31;   // exponent magnitude, Q.25, up to 2^30
  localparam int E30_W   = 36;   // exponent in Q.30
  localparam int N_W     = 6;    // power of two count after ln2 reduction
  localparam int R_W     = 30;   // reduced argument, Q.30
  localparam int TERM_W  = 31;   // Taylor term, Q.30
  localparam int ACC_W   = 32;   // Taylor sum
  localparam int REC_W   = 35;   // reciprocal constant
  localparam int REC_SH  = 34;   // reciprocal scale
  localparam int FRAC_SH = 30;
  localparam int TAYLOR_TERMS = 14;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [R_W-1:0]    LN2_Q30    = 30'd744261118;
  localparam logic [TERM_W-1:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [E_W-1:0]    E_FLUSH    = 31'h4000_0000;
  localparam logic [Q_W-1:0]    CORE_T_MAX = 30'd32768;

  localparam logic [W_W-1:0]     WIDTH_RST  = 16'd16384;
  localparam logic [SLOPE_W-1:0] SLOPE_RST  = 15'd4096;

  typedef enum logic [2:0] {
    REG_CENTER      = 3'd0,
    REG_WIDTH_LEFT  = 3'd1,
    REG_WIDTH_RIGHT = 3'd2,
    REG_SLOPE_LEFT  = 3'd3,
    REG_SLOPE_RIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    REGION_LEFT  = 2'd0,
    REGION_CORE  = 2'd1,
    REGION_RIGHT = 2'd2
  } region_t;

  typedef struct packed {
    logic               below;
    logic [SLOPE_W-1:0] slope;
  } div_tag_t;

  typedef struct packed {
    region_t region;
    logic    flush;
  } exp_tag_t;

  // ceil(2^34 / k): floor(x / k) == (x * M) >> 34 for x < 2^30, k <= 14
  function automatic logic [REC_W-1:0] recip(input int k);
    logic [REC_W-1:0] m;
    case (k)
      1:       m = 35'd17179869184;
      2:       m = 35'd8589934592;
      3:       m = 35'd5726623062;
      4:       m = 35'd4294967296;
      5:       m = 35'd3435973837;
      6:       m = 35'd2863311531;
      7:       m = 35'd2454267027;
      8:       m = 35'd2147483648;
      9:       m = 35'd1908874354;
      10:      m = 35'd1717986919;
      11:      m = 35'd1561806290;
      12:      m = 35'd1431655766;
      13:      m = 35'd1321528399;
      14:      m = 35'd1227133514;
      default: m = 35'd17179869184;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/egx_sample_if.sv
// ============================================================================
// egx_sample_if: sample channel
// valid/ready channel carrying one signed Q4.12 sample per beat.
// ============================================================================
`default_nettype none

interface egx_sample_if;
  logic                              valid;
  logic                              ready;
  logic signed [egx_pkg::X_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/egx_result_if.sv
// ============================================================================
// egx_result_if: result channel
// valid/ready channel carrying shape value and region per beat.
// ============================================================================
`default_nettype none

interface egx_result_if #(
  parameter int FRAC_BITS = egx_pkg::OUT_FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   shape_value;
  logic [1:0]           region;

  modport source (output valid, output shape_value, output region, input ready);
  modport sink   (input valid, input shape_value, input region, output ready);
endinterface

`default_nettype wire

>>> rtl/egx_div.sv
// ============================================================================
// egx_div: pipelined restoring divider
// One quotient bit per stage, NUM_W stages, sideband tag carried along.
// ============================================================================
`default_nettype none

module egx_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [egx_pkg::NUM_W-1:0]   in_num,
  input  wire logic [egx_pkg::W_W-1:0]     in_den,
  input  wire egx_pkg::div_tag_t           in_tag,
  output logic                             out_valid,
  output logic [egx_pkg::Q_W-1:0]          out_quot,
  output egx_pkg::div_tag_t                out_tag
);

  localparam int STAGES = egx_pkg::NUM_W;
  localparam int WW     = egx_pkg::W_W;

  logic [STAGES-1:0]             vld;
  logic [WW-1:0]                 rem      [STAGES];
  logic [egx_pkg::NUM_W-1:0]     num      [STAGES];
  logic [egx_pkg::Q_W-1:0]       quot     [STAGES];
  logic [WW-1:0]                 den      [STAGES];
  egx_pkg::div_tag_t             tag      [STAGES];

  logic [WW-1:0]                 rem_next [STAGES];
  logic [egx_pkg::NUM_W-1:0]     num_next [STAGES];
  logic [egx_pkg::Q_W-1:0]       quot_next[STAGES];
  logic [WW-1:0]                 den_next [STAGES];
  egx_pkg::div_tag_t             tag_next [STAGES];
  logic [STAGES-1:0]             vld_next;

  always_comb begin
    logic [WW-1:0]             src_rem;
    logic [egx_pkg::NUM_W-1:0] src_num;
    logic [egx_pkg::Q_W-1:0]   src_quot;
    logic [WW-1:0]             src_den;
    logic [WW:0]               rsh;
    logic                      ge;
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        src_rem     = '0;
        src_num     = in_num;
        src_quot    = '0;
        src_den     = in_den;
        tag_next[s] = in_tag;
        vld_next[s] = in_valid;
      end else begin
        src_rem     = rem[s-1];
        src_num     = num[s-1];
        src_quot    = quot[s-1];
        src_den     = den[s-1];
        tag_next[s] = tag[s-1];
        vld_next[s] = vld[s-1];
      end
      rsh          = {src_rem, src_num[egx_pkg::NUM_W-1]};
      ge           = (rsh >= {1'b0, src_den});
      rem_next[s]  = ge ? WW'(rsh - {1'b0, src_den}) : rsh[WW-1:0];
      num_next[s]  = {src_num[egx_pkg::NUM_W-2:0], 1'b0};
      quot_next[s] = {src_quot[egx_pkg::Q_W-2:0], ge};
      den_next[s]  = src_den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        rem[s]  <= rem_next[s];
        num[s]  <= num_next[s];
        quot[s] <= quot_next[s];
        den[s]  <= den_next[s];
        tag[s]  <= tag_next[s];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_quot  = quot[STAGES-1];
  assign out_tag   = tag[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/egx_exp.sv
// ============================================================================
// egx_exp: pipelined exp(-E) evaluator
// ln2 range reduction (one quotient bit per stage), then a Taylor series through
// r^14, two stages per term (product, then divide by k via reciprocal).
// ============================================================================
`default_nettype none

module egx_exp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [egx_pkg::E_W-1:0]   in_e,
  input  wire egx_pkg::exp_tag_t         in_tag,
  output logic                           out_valid,
  output logic [egx_pkg::ACC_W-1:0]      out_sum,
  output logic [egx_pkg::N_W-1:0]        out_n,
  output egx_pkg::exp_tag_t              out_tag
);

  localparam int RED = egx_pkg::N_W;
  localparam int NT  = egx_pkg::TAYLOR_TERMS;
  localparam int RW  = egx_pkg::R_W;
  localparam int AW  = egx_pkg::ACC_W;
  localparam int TW  = egx_pkg::TERM_W;
  localparam int NW  = egx_pkg::N_W;
  localparam int XW  = egx_pkg::E30_W;

  // range reduction stages
  logic [RED-1:0]            rd_vld, rd_vld_next;
  logic [XW-1:0]             rd_x     [RED];
  logic [XW-1:0]             rd_x_next[RED];
  logic [NW-1:0]             rd_n     [RED];
  logic [NW-1:0]             rd_n_next[RED];
  egx_pkg::exp_tag_t         rd_tag     [RED];
  egx_pkg::exp_tag_t         rd_tag_next[RED];

  // Taylor product stages (A) and divide stages (B)
  logic [NT-1:0]             a_vld, a_vld_next, b_vld, b_vld_next;
  logic [RW-1:0]             a_x      [NT];
  logic [RW-1:0]             a_x_next [NT];
  logic [AW-1:0]             a_acc     [NT];
  logic [AW-1:0]             a_acc_next[NT];
  logic [RW-1:0]             a_r      [NT];
  logic [RW-1:0]             a_r_next [NT];
  logic [NW-1:0]             a_n      [NT];
  logic [NW-1:0]             a_n_next [NT];
  egx_pkg::exp_tag_t         a_tag      [NT];
  egx_pkg::exp_tag_t         a_tag_next [NT];
  logic [TW-1:0]             b_term     [NT];
  logic [TW-1:0]             b_term_next[NT];
  logic [AW-1:0]             b_acc     [NT];
  logic [AW-1:0]             b_acc_next[NT];
  logic [RW-1:0]             b_r      [NT];
  logic [RW-1:0]             b_r_next [NT];
  logic [NW-1:0]             b_n      [NT];
  logic [NW-1:0]             b_n_next [NT];
  egx_pkg::exp_tag_t         b_tag      [NT];
  egx_pkg::exp_tag_t         b_tag_next [NT];

  logic                      o_vld;
  logic [AW-1:0]             o_sum;
  logic [NW-1:0]             o_n;
  egx_pkg::exp_tag_t         o_tag;

  always_comb begin
    logic [XW-1:0]     sx;
    logic [NW-1:0]     sn;
    logic [XW-1:0]     ln2_sh;
    logic              ge;
    logic [TW-1:0]     pterm;
    logic [AW-1:0]     pacc;
    logic [RW+TW-1:0]  prod;
    logic [RW+egx_pkg::REC_W-1:0] qprod;
    for (int j = 0; j < RED; j++) begin
      if (j == 0) begin
        sx             = {in_e, 5'b0};
        sn             = '0;
        rd_tag_next[j] = in_tag;
        rd_vld_next[j] = in_valid;
      end else begin
        sx             = rd_x[j-1];
        sn             = rd_n[j-1];
        rd_tag_next[j] = rd_tag[j-1];
        rd_vld_next[j] = rd_vld[j-1];
      end
      ln2_sh       = XW'({6'b0, egx_pkg::LN2_Q30} << (RED - 1 - j));
      ge           = (sx >= ln2_sh);
      rd_x_next[j] = ge ? sx - ln2_sh : sx;
      rd_n_next[j] = {sn[NW-2:0], ge};
    end

    for (int k = 0; k < NT; k++) begin
      // A stage: fold in previous term, multiply it by r
      if (k == 0) begin
        pterm         = egx_pkg::ONE_Q30;
        pacc          = '0;
        a_r_next[k]   = rd_x[RED-1][RW-1:0];
        a_n_next[k]   = rd_n[RED-1];
        a_tag_next[k] = rd_tag[RED-1];
        a_vld_next[k] = rd_vld[RED-1];
      end else begin
        pterm         = b_term[k-1];
        pacc          = b_acc[k-1];
        a_r_next[k]   = b_r[k-1];
        a_n_next[k]   = b_n[k-1];
        a_tag_next[k] = b_tag[k-1];
        a_vld_next[k] = b_vld[k-1];
      end
      a_acc_next[k] = (k % 2 == 0) ? pacc + AW'(pterm) : pacc - AW'(pterm);
      prod          = pterm * a_r_next[k];
      a_x_next[k]   = prod[egx_pkg::FRAC_SH +: RW];

      // B stage: divide by term index through a reciprocal
      qprod          = a_x[k] * egx_pkg::recip(k + 1);
      b_term_next[k] = TW'(qprod[egx_pkg::REC_SH +: RW]);
      b_acc_next[k]  = a_acc[k];
      b_r_next[k]    = a_r[k];
      b_n_next[k]    = a_n[k];
      b_tag_next[k]  = a_tag[k];
      b_vld_next[k]  = a_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= '0;
      a_vld  <= '0;
      b_vld  <= '0;
      o_vld  <= 1'b0;
    end else if (en) begin
      rd_vld <= rd_vld_next;
      a_vld  <= a_vld_next;
      b_vld  <= b_vld_next;
      o_vld  <= b_vld[NT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < RED; j++) begin
        rd_x[j]   <= rd_x_next[j];
        rd_n[j]   <= rd_n_next[j];
        rd_tag[j] <= rd_tag_next[j];
      end
      for (int k = 0; k < NT; k++) begin
        a_x[k]    <= a_x_next[k];
        a_acc[k]  <= a_acc_next[k];
        a_r[k]    <= a_r_next[k];
        a_n[k]    <= a_n_next[k];
        a_tag[k]  <= a_tag_next[k];
        b_term[k] <= b_term_next[k];
        b_acc[k]  <= b_acc_next[k];
        b_r[k]    <= b_r_next[k];
        b_n[k]    <= b_n_next[k];
        b_tag[k]  <= b_tag_next[k];
      end
      // last term has an even index: added
      o_sum <= b_acc[NT-1] + AW'(b_term[NT-1]);
      o_n   <= b_n[NT-1];
      o_tag <= b_tag[NT-1];
    end
  end

  assign out_valid = o_vld;
  assign out_sum   = o_sum;
  assign out_n     = o_n;
  assign out_tag   = o_tag;

endmodule

`default_nettype wire

>>> rtl/exp_gauss_exp_shape_eval_top.sv
// ============================================================================
// exp_gauss_exp_shape_eval_top: ExpGaussExp shape evaluator
// Streams samples to unnormalized ExpGaussExp values with region codes.
// ============================================================================
//
//  channel   | kind        | beat contents
//  ----------+-------------+---------------------------------------------
//  samples   | valid/ready | sample (Q4.12 signed)
//  results   | valid/ready | shape_value (Q1.OUT_FRAC_BITS), region
//  apb       | APB         | center, width_left/right, slope_left/right
//
//  One sample enters per cycle while results is not stalled. The pipeline is
//  the 30-stage divider for t, 6 ln2 reduction stages and two stages per
//  Taylor term (14 terms), plus six arithmetic/output stages.
//  rst is synchronous and clears all valid bits and the config registers.
//  A stalled results channel freezes the whole pipeline in place; nothing
//  is dropped or repeated, and samples.ready follows the stall directly.
// ============================================================================
`default_nettype none

module exp_gauss_exp_shape_eval_top #(
  parameter int OUT_FRAC_BITS = egx_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [egx_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [egx_pkg::DATA_W-1:0]    pwdata,
  output logic      [egx_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  egx_sample_if.sink                         samples,
  egx_result_if.source                       results
);

  localparam int SH_BASE = egx_pkg::FRAC_SH - OUT_FRAC_BITS - 1;

  // ---------------------------------------------------------------- config
  logic [egx_pkg::X_W-1:0]     center;
  logic [egx_pkg::W_W-1:0]     width_left;
  logic [egx_pkg::W_W-1:0]     width_right;
  logic [egx_pkg::SLOPE_W-1:0] slope_left;
  logic [egx_pkg::SLOPE_W-1:0] slope_right;
  egx_pkg::reg_idx_t           reg_idx;

  assign reg_idx = egx_pkg::reg_idx_t'(paddr[egx_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center      <= '0;
      width_left  <= egx_pkg::WIDTH_RST;
      width_right <= egx_pkg::WIDTH_RST;
      slope_left  <= egx_pkg::SLOPE_RST;
      slope_right <= egx_pkg::SLOPE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        egx_pkg::REG_CENTER:      center      <= pwdata[egx_pkg::X_W-1:0];
        egx_pkg::REG_WIDTH_LEFT:  width_left  <= pwdata[egx_pkg::W_W-1:0];
        egx_pkg::REG_WIDTH_RIGHT: width_right <= pwdata[egx_pkg::W_W-1:0];
        egx_pkg::REG_SLOPE_LEFT:  slope_left  <= pwdata[egx_pkg::SLOPE_W-1:0];
        egx_pkg::REG_SLOPE_RIGHT: slope_right <= pwdata[egx_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      egx_pkg::REG_CENTER:      prdata = egx_pkg::DATA_W'(center);
      egx_pkg::REG_WIDTH_LEFT:  prdata = egx_pkg::DATA_W'(width_left);
      egx_pkg::REG_WIDTH_RIGHT: prdata = egx_pkg::DATA_W'(width_right);
      egx_pkg::REG_SLOPE_LEFT:  prdata = egx_pkg::DATA_W'(slope_left);
      egx_pkg::REG_SLOPE_RIGHT: prdata = egx_pkg::DATA_W'(slope_right);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  // single advance enable: pipeline moves unless the output beat is held
  logic en;
  logic out_vld;

  assign en            = !out_vld || results.ready;
  assign samples.ready = en;

  // ------------------------------------------------- stage 1: d, |d|, width
  logic                          p1_vld;
  logic [egx_pkg::MAG_W-1:0]     p1_mag;
  logic [egx_pkg::W_W-1:0]       p1_w;
  egx_pkg::div_tag_t             p1_tag;
  logic [egx_pkg::X_W:0]         d;
  logic [egx_pkg::X_W:0]         d_neg;
  logic                          below;
  logic [egx_pkg::W_W-1:0]       wsel;

  assign d     = {samples.sample[egx_pkg::X_W-1], samples.sample}
               - {center[egx_pkg::X_W-1], center};
  assign d_neg = -d;
  assign below = d[egx_pkg::X_W];
  assign wsel  = below ? width_left : width_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_mag       <= below ? d_neg[egx_pkg::MAG_W-1:0] : d[egx_pkg::MAG_W-1:0];
      p1_w         <= (wsel == '0) ? egx_pkg::W_W'(1) : wsel;  // zero width acts as one LSB
      p1_tag.below <= below;
      p1_tag.slope <= below ? slope_left : slope_right;
    end
  end

  // ------------------------------------------------- divider: |t| = |d|/w
  logic                      dv_vld;
  logic [egx_pkg::Q_W-1:0]   dv_t;
  egx_pkg::div_tag_t         dv_tag;

  egx_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p1_vld),
    .in_num    ({p1_mag, 14'b0}),
    .in_den    (p1_w),
    .in_tag    (p1_tag),
    .out_valid (dv_vld),
    .out_quot  (dv_t),
    .out_tag   (dv_tag)
  );

  // ------------------------------------------------- stage 2: region
  logic                          p2_vld;
  logic [egx_pkg::Q_W-1:0]       p2_t;
  logic [egx_pkg::SLOPE_W-1:0]   p2_slope;
  logic                          p2_tail;
  logic                          p2_big;
  egx_pkg::region_t              p2_region;
  logic                          tail;

  assign tail = dv_t > egx_pkg::Q_W'(dv_tag.slope);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (en) begin
      p2_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_t     <= dv_t;
      p2_slope <= dv_tag.slope;
      p2_tail  <= tail;
      // core with |t| above 2^15 has t^2 beyond the flush limit
      p2_big   <= !tail && (dv_t > egx_pkg::CORE_T_MAX);
      if (!tail) begin
        p2_region <= egx_pkg::REGION_CORE;
      end else if (dv_tag.below) begin
        p2_region <= egx_pkg::REGION_LEFT;
      end else begin
        p2_region <= egx_pkg::REGION_RIGHT;
      end
    end
  end

  // ------------------------------------------------- stage 3: products
  logic                          p3_vld;
  logic [egx_pkg::PROD_W-1:0]    p3_prod;
  logic [egx_pkg::ASQ_W-1:0]     p3_asq;
  logic                          p3_tail;
  logic                          p3_big;
  egx_pkg::region_t              p3_region;
  logic [15:0]                   opa;
  logic [egx_pkg::Q_W-1:0]       opb;

  assign opa = p2_tail ? {1'b0, p2_slope} : p2_t[15:0];
  assign opb = p2_tail ? p2_t : egx_pkg::Q_W'(p2_t[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else if (en) begin
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_prod   <= opa * opb;
      p3_asq    <= p2_slope * p2_slope;
      p3_tail   <= p2_tail;
      p3_big    <= p2_big;
      p3_region <= p2_region;
    end
  end

  // ------------------------------------------------- stage 4: exponent, flush
  logic                          p4_vld;
  logic [egx_pkg::E_W-1:0]       p4_e;
  egx_pkg::exp_tag_t             p4_tag;
  logic [egx_pkg::PROD_W:0]      e_full;

  // tail: 2*a*|t| - a^2, core: |t|^2
  assign e_full = p3_tail ? {p3_prod, 1'b0} - (egx_pkg::PROD_W + 1)'(p3_asq)
                          : {1'b0, p3_prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else if (en) begin
      p4_vld <= p3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_e          <= e_full[egx_pkg::E_W-1:0];
      p4_tag.region <= p3_region;
      p4_tag.flush  <= p3_big || (e_full > (egx_pkg::PROD_W + 1)'(egx_pkg::E_FLUSH));
    end
  end

  // ------------------------------------------------- exp(-E)
  logic                          ex_vld;
  logic [egx_pkg::ACC_W-1:0]     ex_sum;
  logic [egx_pkg::N_W-1:0]       ex_n;
  egx_pkg::exp_tag_t             ex_tag;

  egx_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p4_vld),
    .in_e      (p4_e),
    .in_tag    (p4_tag),
    .out_valid (ex_vld),
    .out_sum   (ex_sum),
    .out_n     (ex_n),
    .out_tag   (ex_tag)
  );

  // ------------------------------------------------- output: scale and round
  // (v + 2^(s-1)) >> s == ((v >> (s-1)) + 1) >> 1
  logic [7:0]                    sh;
  logic [egx_pkg::ACC_W-1:0]     q;
  logic [egx_pkg::ACC_W:0]       q_inc;
  logic [OUT_FRAC_BITS:0]        shape_value;
  logic [OUT_FRAC_BITS:0]        out_shape;
  logic [1:0]                    out_region;

  assign sh    = 8'(SH_BASE) + 8'(ex_n);
  assign q     = (sh >= 8'(egx_pkg::ACC_W)) ? '0 : ex_sum >> sh[4:0];
  assign q_inc = {1'b0, q} + 1'b1;
  assign shape_value = ex_tag.flush ? '0 : q_inc[OUT_FRAC_BITS+1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= ex_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_shape  <= shape_value;
      out_region <= ex_tag.region;
    end
  end

  assign results.valid       = out_vld;
  assign results.shape_value = out_shape;
  assign results.region      = out_region;

endmodule

`default_nettype wire
